// ===== hdl/asps_pkg.sv =====
// Shared types, widths and constants of the asinh pixel stretch core.
// Also holds the elaboration-time builder of the base-2 logarithm table.
// Depends on nothing.
package asps_pkg;

	localparam int PIXEL_BITS_DEF     = 16;
	localparam int LOG_TABLE_BITS_DEF = 10;

	// Register widths.
	localparam int BP_W    = 16;
	localparam int Q_W     = 15;
	localparam int ALPHA_W = 17;
	localparam int GAIN_W  = 15;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;

	// Reset values of the registers.
	localparam logic [BP_W-1:0]    BP_RESET    = 16'd0;
	localparam logic [Q_W-1:0]     Q_RESET     = 15'd2048;
	localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd3277;
	localparam logic [GAIN_W-1:0]  GAIN_RESET  = 15'd4096;

	// Black point scale divisor (code/65535).
	localparam logic [BP_W:0] BP_SCALE = 17'd65535;

	// Datapath widths.
	localparam int X_W     = 17;  // normalised level, Q16, at most 1.0
	localparam int XPROD_W = 32;  // softening_q * x
	localparam int T_W     = 39;  // t, Q16.16
	localparam int T_SMALL = 24;  // t below 2^24 takes the square-root path
	localparam int ROOT_W  = 25;  // isqrt(t*t + 2^32)
	localparam int S_W     = 40;  // s, Q16.16
	localparam int LG_W    = 17;  // table entry, Q16
	localparam int IP_W    = 5;   // integer part of the logarithm
	localparam int L_W     = 21;  // logarithm, Q16
	localparam int LPROD_W = 36;  // logarithm * final_gain
	localparam int R_W     = 29;  // ratio, Q3.26
	localparam int R_FRAC  = 26;

	localparam logic [R_W-1:0] R_ONE = R_W'(1) << R_FRAC;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BLACK_POINT = 2'd0,
		REG_SOFTENING_Q = 2'd1,
		REG_NOISE_FLOOR = 2'd2,
		REG_FINAL_GAIN  = 2'd3
	} asps_reg_t;

	typedef enum logic [1:0] {
		CAL_LOAD,
		CAL_DIV,
		CAL_SEND,
		CAL_RUN
	} asps_state_t;

	// Flags that travel with each item down the pipeline.
	typedef struct packed {
		logic cal;   // calibration token: computes the log of the maximum
		logic zero;  // result forced to zero (at or below the black point)
	} asps_flags_t;

	// Control from the configuration block to the pipeline entry.
	typedef struct packed {
		logic run;     // pixels may be taken
		logic inject;  // a calibration token is waiting to enter
	} asps_ctl_t;

	// One entry of log2(1 + i/2^tb) in Q16, by repeated squaring in Q2.30.
	function automatic logic [LG_W-1:0] lg_entry(int unsigned i, int unsigned tb);
		longint unsigned y;
		logic [LG_W-1:0] r;
		y = (longint'(1) << 30) + (longint'(i) << (30 - tb));
		r = '0;
		if (i >= (32'd1 << tb)) begin
			r = LG_W'(32'd65536);
		end else begin
			for (int k = 0; k < 16; k++) begin
				y = (y * y) >> 30;
				r = LG_W'({r, 1'b0});
				if (y >= (longint'(1) << 31)) begin
					r[0] = 1'b1;
					y = y >> 1;
				end
			end
		end
		return r;
	endfunction

endpackage

// ===== hdl/asps_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// The caller must hold the divisor steady while items are in flight; this block does not enforce it.
// Depends on asps_pkg.
module asps_div_pipe #(
	parameter int NW = 39,
	parameter int DW = 17,
	parameter int QW = 39,
	parameter int TW = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] in_num,
	input  logic [TW-1:0] in_tag,
	input  logic [DW-1:0] div,
	output logic          out_valid,
	output logic [QW-1:0] out_quo,
	output logic [TW-1:0] out_tag
);
	import asps_pkg::*;

	// The quotient is known to fit in QW bits, so the top part of the
	// numerator starts as the partial remainder.
	logic [QW+DW-1:0] nfull;
	logic             v_s   [QW];
	logic [DW-1:0]    rem_s [QW];
	logic [QW-1:0]    low_s [QW];
	logic [QW-1:0]    quo_s [QW];
	logic [TW-1:0]    tag_s [QW];

	assign nfull = (QW+DW)'(in_num);

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic          pv;
		logic [DW-1:0] prem;
		logic [QW-1:0] plow;
		logic [QW-1:0] pquo;
		logic [TW-1:0] ptag;
		logic [DW:0]   trial;
		logic          ge;

		if (k == 0) begin : g_first
			assign pv   = in_valid;
			assign prem = nfull[QW+DW-1:QW];
			assign plow = nfull[QW-1:0];
			assign pquo = '0;
			assign ptag = in_tag;
		end else begin : g_next
			assign pv   = v_s[k-1];
			assign prem = rem_s[k-1];
			assign plow = low_s[k-1];
			assign pquo = quo_s[k-1];
			assign ptag = tag_s[k-1];
		end

		assign trial = {prem, plow[QW-1-k]};
		assign ge    = trial >= {1'b0, div};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? DW'(trial - {1'b0, div}) : DW'(trial);
				low_s[k] <= plow;
				quo_s[k] <= QW'({pquo, ge});
				tag_s[k] <= ptag;
			end
		end
	end

	assign out_valid = v_s[QW-1];
	assign out_quo   = quo_s[QW-1];
	assign out_tag   = tag_s[QW-1];

endmodule

// ===== hdl/asps_sqrt_pipe.sv =====
// Pipelined integer square root, one result bit per register stage.
// Floor of the root of a 2*RW bit operand. Depends on asps_pkg.
module asps_sqrt_pipe #(
	parameter int RW = 25,
	parameter int TW = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [2*RW-1:0] in_n,
	input  logic [TW-1:0]   in_tag,
	output logic            out_valid,
	output logic [RW-1:0]   out_root,
	output logic [TW-1:0]   out_tag
);
	import asps_pkg::*;

	logic            v_s    [RW];
	logic [RW+1:0]   rem_s  [RW];
	logic [RW-1:0]   root_s [RW];
	logic [2*RW-1:0] n_s    [RW];
	logic [TW-1:0]   tag_s  [RW];

	for (genvar k = 0; k < RW; k++) begin : g_stage
		logic            pv;
		logic [RW+1:0]   prem;
		logic [RW-1:0]   proot;
		logic [2*RW-1:0] pn;
		logic [TW-1:0]   ptag;
		logic [RW+1:0]   remsh;
		logic [RW+1:0]   trial;
		logic            ge;

		if (k == 0) begin : g_first
			assign pv    = in_valid;
			assign prem  = '0;
			assign proot = '0;
			assign pn    = in_n;
			assign ptag  = in_tag;
		end else begin : g_next
			assign pv    = v_s[k-1];
			assign prem  = rem_s[k-1];
			assign proot = root_s[k-1];
			assign pn    = n_s[k-1];
			assign ptag  = tag_s[k-1];
		end

		// Bring down the next pair of operand bits and try root*4+1.
		assign remsh = (RW+2)'({prem, pn[2*(RW-1-k)+1], pn[2*(RW-1-k)]});
		assign trial = {proot, 2'b01};
		assign ge    = remsh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? remsh - trial : remsh;
				root_s[k] <= RW'({proot, ge});
				n_s[k]    <= pn;
				tag_s[k]  <= ptag;
			end
		end
	end

	assign out_valid = v_s[RW-1];
	assign out_root  = root_s[RW-1];
	assign out_tag   = tag_s[RW-1];

endmodule

// ===== hdl/asps_log2.sv =====
// Base-2 logarithm in Q16 of a Q16.16 value of at least 1.0: two normalise
// stages, a table read with interpolation over three more. Depends on asps_pkg.
module asps_log2 #(
	parameter int LOG_TABLE_BITS = asps_pkg::LOG_TABLE_BITS_DEF,
	parameter int TW = 2
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  logic [asps_pkg::S_W-1:0] in_s,
	input  logic [TW-1:0]           in_tag,
	output logic                    out_valid,
	output logic [asps_pkg::L_W-1:0] out_log,
	output logic [TW-1:0]           out_tag
);
	import asps_pkg::*;

	localparam int Size   = 1 << LOG_TABLE_BITS;
	localparam int AW     = LOG_TABLE_BITS + 1;
	localparam int FS     = 32 - LOG_TABLE_BITS;
	localparam int IpTop  = S_W - 1 - 16;

	logic [LG_W-1:0] lg_rom [Size+1];

	for (genvar g = 0; g <= Size; g++) begin : g_rom
		assign lg_rom[g] = lg_entry(g, LOG_TABLE_BITS);
	end

	logic [S_W-1:0]     m_a, m_b, m_c, m_d, m_e;
	logic [31:0]        f32;
	logic [AW-1:0]      idx;

	logic               v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [TW-1:0]      tag_s1, tag_s2, tag_s3, tag_s4, tag_s5;
	logic [S_W-1:0]     m_s1, m_s2;
	logic [IP_W-1:0]    sh_s1, sh_s2;
	logic [LG_W-1:0]    a_s3, b_s3, a_s4;
	logic [FS-1:0]      rem_s3;
	logic [IP_W-1:0]    ip_s3, ip_s4;
	logic [LG_W+FS-1:0] pr_s4;
	logic [L_W-1:0]     log_s5;

	// Coarse normalise: shifts of 16 and 8.
	assign m_a = (in_s[S_W-1 -: 16] == '0) ? (in_s << 16) : in_s;
	assign m_b = (m_a[S_W-1 -: 8] == '0) ? (m_a << 8) : m_a;
	// Fine normalise: shifts of 4, 2 and 1.
	assign m_c = (m_s1[S_W-1 -: 4] == '0) ? (m_s1 << 4) : m_s1;
	assign m_d = (m_c[S_W-1 -: 2] == '0) ? (m_c << 2) : m_c;
	assign m_e = (m_d[S_W-1] == 1'b0) ? (m_d << 1) : m_d;

	// Mantissa bits below the leading one, aligned to 32 bits.
	assign f32 = m_s2[S_W-2 -: 32];
	assign idx = AW'(f32[31 -: LOG_TABLE_BITS]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s1   <= m_b;
			sh_s1  <= {in_s[S_W-1 -: 16] == '0, m_a[S_W-1 -: 8] == '0, 3'b000};
			tag_s1 <= in_tag;

			m_s2   <= m_e;
			sh_s2  <= sh_s1 | {2'b00, m_s1[S_W-1 -: 4] == '0, m_c[S_W-1 -: 2] == '0,
				m_d[S_W-1] == 1'b0};
			tag_s2 <= tag_s1;

			a_s3   <= lg_rom[idx];
			b_s3   <= lg_rom[idx + AW'(1)];
			rem_s3 <= f32[FS-1:0];
			ip_s3  <= IP_W'(IpTop) - sh_s2;
			tag_s3 <= tag_s2;

			pr_s4  <= (b_s3 - a_s3) * rem_s3;
			a_s4   <= a_s3;
			ip_s4  <= ip_s3;
			tag_s4 <= tag_s3;

			log_s5 <= L_W'({ip_s4, 16'h0000}) + L_W'(a_s4) + L_W'(pr_s4[LG_W+FS-1:FS]);
			tag_s5 <= tag_s4;
		end
	end

	assign out_valid = v_s5;
	assign out_log   = log_s5;
	assign out_tag   = tag_s5;

endmodule

// ===== hdl/asps_cfg.sv =====
// Configuration registers and calibration sequencer: scales the black point
// with a constant multiply and then issues a calibration token. Uses asps_pkg.
module asps_cfg #(
	parameter int PIXEL_BITS = asps_pkg::PIXEL_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [asps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [asps_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                          en,
	output logic [PIXEL_BITS-1:0]         bpp,
	output logic [asps_pkg::Q_W-1:0]      softening_q,
	output logic [asps_pkg::ALPHA_W-1:0]  alpha,
	output logic [asps_pkg::GAIN_W-1:0]   final_gain,
	output asps_pkg::asps_ctl_t           ctl
);
	import asps_pkg::*;

	localparam int P = PIXEL_BITS;
	// 2^P = BP_SCALE * PwrQuo + PwrRem, so black_point * (2^P - 1) / BP_SCALE is
	// black_point * PwrQuo plus the floor of black_point * (PwrRem - 1) / BP_SCALE.
	localparam longint unsigned PwrQuo = (64'd1 << P) / 64'(BP_SCALE);
	localparam longint unsigned PwrRem = (64'd1 << P) % 64'(BP_SCALE);

	logic [BP_W-1:0]    bp_q;
	logic [Q_W-1:0]     q_q;
	logic [ALPHA_W-1:0] nf_q;
	logic [GAIN_W-1:0]  gain_q;

	asps_state_t        state_q, state_d;
	logic [P-1:0]       whole_q;
	logic [31:0]        part_q;
	logic [P-1:0]       bpp_q;

	logic [32:0]        part_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bp_q   <= BP_RESET;
			q_q    <= Q_RESET;
			nf_q   <= ALPHA_RESET;
			gain_q <= GAIN_RESET;
		end else if (cfg_we) begin
			unique case (asps_reg_t'(cfg_index))
				REG_BLACK_POINT: bp_q   <= cfg_data[BP_W-1:0];
				REG_SOFTENING_Q: q_q    <= cfg_data[Q_W-1:0];
				REG_NOISE_FLOOR: nf_q   <= cfg_data[ALPHA_W-1:0];
				REG_FINAL_GAIN:  gain_q <= cfg_data[GAIN_W-1:0];
			endcase
		end
	end

	// Division by 2^16 - 1 of a value below 2^32: add the upper half back in,
	// plus one, and keep the upper half of the sum.
	assign part_sum = 33'(part_q) + 33'(part_q >> 16) + 33'd1;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			CAL_LOAD: state_d = CAL_DIV;
			CAL_DIV:  state_d = CAL_SEND;
			CAL_SEND: if (en) state_d = CAL_RUN;
			CAL_RUN:  state_d = CAL_RUN;
		endcase
		if (cfg_we) begin
			state_d = CAL_LOAD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CAL_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// The two products are taken in the load cycle and summed in the next one.
	always_ff @(posedge clk) begin
		if (state_q == CAL_LOAD) begin
			whole_q <= P'(64'(bp_q) * PwrQuo);
			part_q  <= 32'(64'(bp_q) * (PwrRem - 64'd1));
		end else if (state_q == CAL_DIV) begin
			bpp_q   <= whole_q + P'(part_sum[32:16]);
		end
	end

	assign bpp         = bpp_q;
	assign softening_q = q_q;
	assign alpha       = (nf_q == '0) ? ALPHA_W'(1) : nf_q;
	assign final_gain  = gain_q;
	assign ctl.run     = state_q == CAL_RUN;
	assign ctl.inject  = state_q == CAL_SEND;

endmodule

// ===== hdl/asinh_pixel_stretch_core.sv =====
// Top level of the asinh pixel stretch core.
// Instantiates asps_cfg, asps_div_pipe, asps_sqrt_pipe and asps_log2; uses asps_pkg.
//
// Usage
// -----
// Pixels enter on the in_valid / in_ready channel (pixel_in) and leave on the
// out_valid / out_ready channel (pixel_out, clipped). A transfer happens on a
// rising edge where valid and ready are both high. One pixel can be taken on
// every clock while the sequencer runs and the output does not stall; each result
// passes through the entry register, the three one-bit-per-stage dividers (17, 39
// and 29 stages), the 25-stage square root and the log table stages.
// The whole pipeline advances together: when a result waits in the output
// register and out_ready is low, every stage holds and in_ready drops, so
// nothing is lost or repeated. With out_ready high, in_ready follows the
// sequencer alone.
// After reset, and after every register write, the block recomputes the scaled
// black point in its load and divide states and then sends one internal calibration token
// down the pipeline to find the logarithm of the full-scale level; in_ready
// stays low while this happens, and the send waits while the output stalls.
// The user must write registers through cfg_we / cfg_index / cfg_data only while
// no pixel is in flight; the block itself does not enforce this.
module asinh_pixel_stretch_core #(
	parameter int PIXEL_BITS     = asps_pkg::PIXEL_BITS_DEF,
	parameter int LOG_TABLE_BITS = asps_pkg::LOG_TABLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [asps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [asps_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [PIXEL_BITS-1:0]         pixel_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [PIXEL_BITS-1:0]         pixel_out,
	output logic                          clipped
);
	import asps_pkg::*;

	localparam int P   = PIXEL_BITS;
	localparam int FW  = $bits(asps_flags_t);
	localparam int STW = T_W + 1 + FW;
	localparam int PMW = R_FRAC + 1 + P;
	localparam logic [P-1:0]   PMax  = '1;
	localparam logic [X_W-1:0] XOne  = X_W'(1) << 16;

	// Global advance: the pipeline moves unless a result is stuck at the output.
	logic en;

	logic [P-1:0]       bpp;
	logic [Q_W-1:0]     softening_q;
	logic [ALPHA_W-1:0] alpha;
	logic [GAIN_W-1:0]  final_gain;
	asps_ctl_t          ctl;

	logic [L_W-1:0] lm_q;  // logarithm of the full-scale level

	// Entry stage.
	logic        valid_s1;
	asps_flags_t flags_s1;
	logic [P-1:0] diff_s1;

	// Normalised level x.
	logic           xv;
	logic [X_W-1:0] xq;
	logic [FW-1:0]  xtag;
	asps_flags_t    xflags;

	logic               valid_s2;
	asps_flags_t        flags_s2;
	logic [XPROD_W-1:0] prod_s2;

	// t = q * x * 256 / alpha.
	logic           tv;
	logic [T_W-1:0] tq;
	logic [FW-1:0]  ttag;

	logic              valid_s3;
	asps_flags_t       flags_s3;
	logic [T_W-1:0]    t_s3;
	logic              big_s3;
	logic [2*T_SMALL-1:0] sq_s3;

	// Square root of t*t + 1.
	logic              rv;
	logic [ROOT_W-1:0] rroot;
	logic [STW-1:0]    rtag;
	logic [T_W-1:0]    rt;
	logic              rbig;
	asps_flags_t       rflags;

	logic           valid_s4;
	asps_flags_t    flags_s4;
	logic [S_W-1:0] s_s4;

	// Logarithm.
	logic           lv;
	logic [L_W-1:0] llog;
	logic [FW-1:0]  ltag;
	asps_flags_t    lflags;

	logic               valid_s5;
	logic               zero_s5;
	logic [LPROD_W-1:0] prod_s5;

	// Ratio r = lt * gain * 2^14 / lm.
	logic           qv;
	logic [R_W-1:0] rq;
	logic           qzero;

	logic           valid_s6;
	logic           zero_s6;
	logic           clip_s6;
	logic [PMW-1:0] pm_s6;

	logic         valid_s7;
	logic [P-1:0] pix_s7;
	logic         clip_s7;

	assign en       = ~valid_s7 | out_ready;
	assign in_ready = en & ctl.run;

	asps_cfg #(
		.PIXEL_BITS(P)
	) u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.en         (en),
		.bpp        (bpp),
		.softening_q(softening_q),
		.alpha      (alpha),
		.final_gain (final_gain),
		.ctl        (ctl)
	);

	// Entry: a pixel transfer or the calibration token.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= (in_valid & in_ready) | ctl.inject;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flags_s1.cal  <= ctl.inject;
			flags_s1.zero <= ~ctl.inject & (pixel_in <= bpp);
			diff_s1       <= pixel_in - bpp;
		end
	end

	// x = (v - bpp) * 2^16 / (PMAX - bpp).
	asps_div_pipe #(
		.NW(P + 16),
		.DW(P),
		.QW(X_W),
		.TW(FW)
	) u_xdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (valid_s1),
		.in_num   ({diff_s1, 16'h0000}),
		.in_tag   (flags_s1),
		.div      (PMax - bpp),
		.out_valid(xv),
		.out_quo  (xq),
		.out_tag  (xtag)
	);

	assign xflags = asps_flags_t'(xtag);

	// The calibration token stands for a pixel at full scale.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= xv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flags_s2 <= xflags;
			prod_s2  <= XPROD_W'(softening_q * (xflags.cal ? XOne : xq));
		end
	end

	asps_div_pipe #(
		.NW(T_W),
		.DW(ALPHA_W),
		.QW(T_W),
		.TW(FW)
	) u_tdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (valid_s2),
		.in_num   ({prod_s2[T_W-9:0], 8'h00}),
		.in_tag   (flags_s2),
		.div      (alpha),
		.out_valid(tv),
		.out_quo  (tq),
		.out_tag  (ttag)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= tv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flags_s3 <= asps_flags_t'(ttag);
			t_s3     <= tq;
			big_s3   <= |tq[T_W-1:T_SMALL];
			sq_s3    <= tq[T_SMALL-1:0] * tq[T_SMALL-1:0];
		end
	end

	// Large t uses s = 2t; the root is still computed but then ignored.
	asps_sqrt_pipe #(
		.RW(ROOT_W),
		.TW(STW)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (valid_s3),
		.in_n     ((2*ROOT_W)'(sq_s3) + ((2*ROOT_W)'(1) << 32)),
		.in_tag   ({t_s3, big_s3, flags_s3}),
		.out_valid(rv),
		.out_root (rroot),
		.out_tag  (rtag)
	);

	assign rt     = rtag[STW-1 -: T_W];
	assign rbig   = rtag[FW];
	assign rflags = asps_flags_t'(rtag[FW-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= rv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flags_s4 <= rflags;
			s_s4     <= rbig ? S_W'({rt, 1'b0}) : S_W'(rt) + S_W'(rroot);
		end
	end

	asps_log2 #(
		.LOG_TABLE_BITS(LOG_TABLE_BITS),
		.TW(FW)
	) u_log (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (valid_s4),
		.in_s     (s_s4),
		.in_tag   (flags_s4),
		.out_valid(lv),
		.out_log  (llog),
		.out_tag  (ltag)
	);

	assign lflags = asps_flags_t'(ltag);

	// The calibration token leaves its logarithm here and goes no further;
	// the pixels behind it see the new value when they reach the divider.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lm_q     <= '0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			if (lv & lflags.cal) begin
				lm_q <= llog;
			end
			valid_s5 <= lv & ~lflags.cal;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s5 <= lflags.zero;
			prod_s5 <= llog * final_gain;
		end
	end

	// The factor 4096 of final_gain times 2^14 in the numerator gives the 2^26 of the ratio.
	asps_div_pipe #(
		.NW(LPROD_W + 14),
		.DW(L_W),
		.QW(R_W),
		.TW(1)
	) u_rdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (valid_s5),
		.in_num   ({prod_s5, 14'h0000}),
		.in_tag   (zero_s5),
		.div      (lm_q),
		.out_valid(qv),
		.out_quo  (rq),
		.out_tag  (qzero)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s6 <= qv;
		end
	end

	// A zero logarithm of full scale (softening_q of zero) also gives zero.
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s6 <= qzero | (lm_q == '0);
			clip_s6 <= rq > R_ONE;
			pm_s6   <= rq[R_FRAC:0] * PMax;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
		end else if (en) begin
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (zero_s6) begin
				pix_s7  <= '0;
				clip_s7 <= 1'b0;
			end else if (clip_s6) begin
				pix_s7  <= PMax;
				clip_s7 <= 1'b1;
			end else begin
				pix_s7  <= pm_s6[R_FRAC+P-1:R_FRAC];
				clip_s7 <= 1'b0;
			end
		end
	end

	assign out_valid = valid_s7;
	assign pixel_out = pix_s7;
	assign clipped   = clip_s7;

endmodule
